### hdl/alpha_overlay_blend_defines.svh
// ---------------------------------------------------------------------------
// alpha_overlay_blend_defines.svh
// assertion macros shared by the overlay blender rtl
// ---------------------------------------------------------------------------
`ifndef ALPHA_OVERLAY_BLEND_DEFINES_SVH
`define ALPHA_OVERLAY_BLEND_DEFINES_SVH

`ifndef SYNTH

// same-cycle implication, checked out of reset
`define AFB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, checked out of reset
`define AFB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define AFB_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define AFB_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

### hdl/afb_pkg.sv
// ---------------------------------------------------------------------------
// afb_pkg
// types and constants of the alpha overlay blender
// ---------------------------------------------------------------------------
package afb_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 14;
    localparam int DIM_W      = 13;
    localparam int POS_W      = 14;
    localparam int CH_W       = 8;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PLACE_X        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PLACE_Y        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OVERLAY_WIDTH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OVERLAY_HEIGHT = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BG_HAS_ALPHA   = 3'd6;

    localparam logic [DIM_W-1:0] RST_FRAME_WIDTH    = 13'd640;
    localparam logic [DIM_W-1:0] RST_FRAME_HEIGHT   = 13'd480;
    localparam logic [DIM_W-1:0] RST_OVERLAY_WIDTH  = 13'd64;
    localparam logic [DIM_W-1:0] RST_OVERLAY_HEIGHT = 13'd64;

    typedef struct packed {
        logic [DIM_W-1:0]        frame_width;
        logic [DIM_W-1:0]        frame_height;
        logic signed [POS_W-1:0] place_x;
        logic signed [POS_W-1:0] place_y;
        logic [DIM_W-1:0]        overlay_width;
        logic [DIM_W-1:0]        overlay_height;
        logic                    bg_has_alpha;
    } t_cfg;

    typedef struct packed {
        logic in_window;
        logic frame_end;
    } t_loc;

    typedef struct packed {
        logic [CH_W-1:0] bg_ch0;
        logic [CH_W-1:0] bg_ch1;
        logic [CH_W-1:0] bg_ch2;
        logic [CH_W-1:0] bg_ch3;
        logic [CH_W-1:0] ovl_ch0;
        logic [CH_W-1:0] ovl_ch1;
        logic [CH_W-1:0] ovl_ch2;
        logic [CH_W-1:0] ovl_alpha;
    } t_pix;

    typedef struct packed {
        logic [CH_W-1:0] out_ch0;
        logic [CH_W-1:0] out_ch1;
        logic [CH_W-1:0] out_ch2;
        logic [CH_W-1:0] out_ch3;
        logic            in_window;
        logic            frame_end;
    } t_res;

endpackage

### hdl/afb_if.sv
// ---------------------------------------------------------------------------
// afb_if
// valid/ready channels of the overlay blender: pixel in, pixel out, config
// ---------------------------------------------------------------------------
interface afb_in_if;
    import afb_pkg::*;

    logic            valid;
    logic            ready;
    logic [CH_W-1:0] bg_ch0;
    logic [CH_W-1:0] bg_ch1;
    logic [CH_W-1:0] bg_ch2;
    logic [CH_W-1:0] bg_ch3;
    logic [CH_W-1:0] ovl_ch0;
    logic [CH_W-1:0] ovl_ch1;
    logic [CH_W-1:0] ovl_ch2;
    logic [CH_W-1:0] ovl_alpha;

    modport source (
        output valid, bg_ch0, bg_ch1, bg_ch2, bg_ch3,
               ovl_ch0, ovl_ch1, ovl_ch2, ovl_alpha,
        input  ready
    );
    modport sink (
        input  valid, bg_ch0, bg_ch1, bg_ch2, bg_ch3,
               ovl_ch0, ovl_ch1, ovl_ch2, ovl_alpha,
        output ready
    );
endinterface

interface afb_out_if;
    import afb_pkg::*;

    logic            valid;
    logic            ready;
    logic [CH_W-1:0] out_ch0;
    logic [CH_W-1:0] out_ch1;
    logic [CH_W-1:0] out_ch2;
    logic [CH_W-1:0] out_ch3;
    logic            in_window;
    logic            frame_end;

    modport source (
        output valid, out_ch0, out_ch1, out_ch2, out_ch3, in_window, frame_end,
        input  ready
    );
    modport sink (
        input  valid, out_ch0, out_ch1, out_ch2, out_ch3, in_window, frame_end,
        output ready
    );
endinterface

interface afb_cfg_if;
    import afb_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### hdl/alpha_overlay_blend.sv
// ---------------------------------------------------------------------------
// alpha_overlay_blend
// alpha-blends an overlay pixel over a raster-order background stream
// ---------------------------------------------------------------------------
//  port     dir  beat
//  i_cfg    in   register index and write data
//  i_px     in   background pixel with aligned overlay pixel
//  o_px     out  blended pixel, window and frame-end flags
//
//  one pixel per clock sustained while o_px is ready; each beat is registered
//  window test happens at input acceptance, blend math between the
//  input register and the result register
//  a full result register that is not taken stalls the input stage only
//  once that stage also holds a pixel
//  i_rst_n is synchronous; no beat is taken while it is low
// ---------------------------------------------------------------------------
`include "alpha_overlay_blend_defines.svh"

module alpha_overlay_blend #(
    parameter int MAX_DIM = 4096
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    afb_cfg_if.sink   i_cfg,
    afb_in_if.sink    i_px,
    afb_out_if.source o_px
);
    import afb_pkg::*;

    t_cfg            cfg;
    t_loc            loc;
    logic            take;
    logic            adv1;
    logic            blend_on;
    logic [CH_W-1:0] res0;
    logic [CH_W-1:0] res1;
    logic [CH_W-1:0] res2;
    logic [CH_W-1:0] res3;

    logic            r_v1;
    t_pix            r_pix;
    t_loc            r_loc;
    logic            r_v2;
    t_res            r_res;
    t_res            n_res;

    afb_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    afb_locate #(
        .MAX_DIM (MAX_DIM)
    ) u_locate (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_step  (take),
        .o_loc   (loc)
    );

    assign adv1       = r_v1 && (!r_v2 || o_px.ready);
    assign i_px.ready = i_rst_n && (!r_v1 || adv1);
    assign take       = i_px.valid && i_px.ready;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (take) begin
            r_v1 <= 1'b1;
        end else if (adv1) begin
            r_v1 <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_pix.bg_ch0    <= i_px.bg_ch0;
            r_pix.bg_ch1    <= i_px.bg_ch1;
            r_pix.bg_ch2    <= i_px.bg_ch2;
            r_pix.bg_ch3    <= i_px.bg_ch3;
            r_pix.ovl_ch0   <= i_px.ovl_ch0;
            r_pix.ovl_ch1   <= i_px.ovl_ch1;
            r_pix.ovl_ch2   <= i_px.ovl_ch2;
            r_pix.ovl_alpha <= i_px.ovl_alpha;
            r_loc           <= loc;
        end
    end

    assign blend_on = r_loc.in_window && (r_pix.ovl_alpha != '0);

    afb_blend u_blend0 (
        .i_bg (r_pix.bg_ch0), .i_ovl (r_pix.ovl_ch0), .i_alpha (r_pix.ovl_alpha),
        .i_en (blend_on), .o_res (res0)
    );
    afb_blend u_blend1 (
        .i_bg (r_pix.bg_ch1), .i_ovl (r_pix.ovl_ch1), .i_alpha (r_pix.ovl_alpha),
        .i_en (blend_on), .o_res (res1)
    );
    afb_blend u_blend2 (
        .i_bg (r_pix.bg_ch2), .i_ovl (r_pix.ovl_ch2), .i_alpha (r_pix.ovl_alpha),
        .i_en (blend_on), .o_res (res2)
    );
    // background alpha blends against the overlay alpha itself
    afb_blend u_blend3 (
        .i_bg (r_pix.bg_ch3), .i_ovl (r_pix.ovl_alpha), .i_alpha (r_pix.ovl_alpha),
        .i_en (blend_on && cfg.bg_has_alpha), .o_res (res3)
    );

    always_comb begin
        n_res.out_ch0   = res0;
        n_res.out_ch1   = res1;
        n_res.out_ch2   = res2;
        n_res.out_ch3   = res3;
        n_res.in_window = r_loc.in_window;
        n_res.frame_end = r_loc.frame_end;
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (adv1) begin
            r_v2 <= 1'b1;
        end else if (o_px.ready) begin
            r_v2 <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_res <= n_res;
        end
    end

    assign o_px.valid     = r_v2;
    assign o_px.out_ch0   = r_res.out_ch0;
    assign o_px.out_ch1   = r_res.out_ch1;
    assign o_px.out_ch2   = r_res.out_ch2;
    assign o_px.out_ch3   = r_res.out_ch3;
    assign o_px.in_window = r_res.in_window;
    assign o_px.frame_end = r_res.frame_end;

    `AFB_ASSERT_NOW(a_full_pipe_stalls, i_clk, i_rst_n, r_v1 && r_v2 && !o_px.ready,
        !i_px.ready)
    `AFB_ASSERT_NEXT(a_result_kept, i_clk, i_rst_n, r_v2 && !o_px.ready, r_v2)
    `AFB_ASSERT_NEXT(a_beat_lands, i_clk, i_rst_n, take, r_v1)
    `AFB_ASSERT_NEXT(a_stage_moves, i_clk, i_rst_n, adv1, r_v2)

endmodule

### hdl/afb_cfg_regs.sv
// ---------------------------------------------------------------------------
// afb_cfg_regs
// configuration register file, one register per index 0 to 6
// ---------------------------------------------------------------------------
module afb_cfg_regs (
    input  logic          i_clk,
    input  logic          i_rst_n,
    afb_cfg_if.sink       i_cfg,
    output afb_pkg::t_cfg o_cfg
);
    import afb_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;
    logic wr;

    assign i_cfg.ready = i_rst_n;
    assign wr          = i_cfg.valid && i_cfg.ready;

    always_comb begin
        n_cfg = r_cfg;
        if (wr) begin
            case (i_cfg.index)
                REG_FRAME_WIDTH:    n_cfg.frame_width    = i_cfg.data[DIM_W-1:0];
                REG_FRAME_HEIGHT:   n_cfg.frame_height   = i_cfg.data[DIM_W-1:0];
                REG_PLACE_X:        n_cfg.place_x        = $signed(i_cfg.data[POS_W-1:0]);
                REG_PLACE_Y:        n_cfg.place_y        = $signed(i_cfg.data[POS_W-1:0]);
                REG_OVERLAY_WIDTH:  n_cfg.overlay_width  = i_cfg.data[DIM_W-1:0];
                REG_OVERLAY_HEIGHT: n_cfg.overlay_height = i_cfg.data[DIM_W-1:0];
                REG_BG_HAS_ALPHA:   n_cfg.bg_has_alpha   = i_cfg.data[0];
                default:            n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_width    <= RST_FRAME_WIDTH;
            r_cfg.frame_height   <= RST_FRAME_HEIGHT;
            r_cfg.place_x        <= '0;
            r_cfg.place_y        <= '0;
            r_cfg.overlay_width  <= RST_OVERLAY_WIDTH;
            r_cfg.overlay_height <= RST_OVERLAY_HEIGHT;
            r_cfg.bg_has_alpha   <= 1'b1;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

### hdl/afb_locate.sv
// ---------------------------------------------------------------------------
// afb_locate
// raster position counters and overlay window test for the current pixel
// ---------------------------------------------------------------------------
`include "alpha_overlay_blend_defines.svh"

module afb_locate #(
    parameter int MAX_DIM = 4096
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  afb_pkg::t_cfg i_cfg,
    input  logic          i_step,
    output afb_pkg::t_loc o_loc
);
    import afb_pkg::*;

    localparam int CW    = $clog2(MAX_DIM);
    localparam int MDW   = $clog2(MAX_DIM + 1);
    localparam int DIMW  = (MDW > DIM_W) ? MDW : DIM_W;
    localparam int SW    = ((CW > POS_W) ? CW : POS_W) + 2;
    localparam logic [DIMW-1:0] MAX_D = DIMW'(MAX_DIM);

    logic [CW-1:0]        r_col;
    logic [CW-1:0]        r_row;
    logic [CW-1:0]        n_col;
    logic [CW-1:0]        n_row;
    logic [DIMW-1:0]      fw;
    logic [DIMW-1:0]      fh;
    logic [DIMW-1:0]      w;
    logic [DIMW-1:0]      h;
    logic                 last_col;
    logic                 last_row;
    logic signed [SW-1:0] fx;
    logic signed [SW-1:0] fy;
    logic                 in_rect;

    // zero size acts as one, oversize clamps to the counter range
    always_comb begin
        fw = DIMW'(i_cfg.frame_width);
        fh = DIMW'(i_cfg.frame_height);
        if (fw == '0) begin
            w = DIMW'(1);
        end else if (fw > MAX_D) begin
            w = MAX_D;
        end else begin
            w = fw;
        end
        if (fh == '0) begin
            h = DIMW'(1);
        end else if (fh > MAX_D) begin
            h = MAX_D;
        end else begin
            h = fh;
        end
    end

    // at-or-past test also wraps counters left beyond a shrunken frame
    assign last_col = DIMW'(r_col) >= (w - DIMW'(1));
    assign last_row = DIMW'(r_row) >= (h - DIMW'(1));

    assign fx = $signed(SW'(r_col)) - SW'(i_cfg.place_x);
    assign fy = $signed(SW'(r_row)) - SW'(i_cfg.place_y);

    assign in_rect = !fx[SW-1] && !fy[SW-1]
                  && (fx < $signed(SW'(i_cfg.overlay_width)))
                  && (fy < $signed(SW'(i_cfg.overlay_height)));

    assign o_loc.in_window = in_rect;
    assign o_loc.frame_end = last_col && last_row;

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (i_step) begin
            if (last_col) begin
                n_col = '0;
                n_row = last_row ? '0 : r_row + CW'(1);
            end else begin
                n_col = r_col + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    `AFB_ASSERT_NEXT(a_frame_wraps, i_clk, i_rst_n, i_step && last_col && last_row,
        r_col == '0 && r_row == '0)
    `AFB_ASSERT_NEXT(a_col_advances, i_clk, i_rst_n, i_step && !last_col,
        r_col == $past(r_col) + CW'(1) && r_row == $past(r_row))
    `AFB_ASSERT_NEXT(a_hold_when_idle, i_clk, i_rst_n, !i_step,
        $stable(r_col) && $stable(r_row))

endmodule

### hdl/afb_blend.sv
// ---------------------------------------------------------------------------
// afb_blend
// one channel of floor((bg*(255-a) + ovl*a) / 255), or passthrough
// ---------------------------------------------------------------------------
module afb_blend (
    input  logic [afb_pkg::CH_W-1:0] i_bg,
    input  logic [afb_pkg::CH_W-1:0] i_ovl,
    input  logic [afb_pkg::CH_W-1:0] i_alpha,
    input  logic                     i_en,
    output logic [afb_pkg::CH_W-1:0] o_res
);
    import afb_pkg::*;

    localparam int PW = 2 * CH_W;

    logic [CH_W-1:0] inv_a;
    logic [PW-1:0]   sum;
    logic [PW-1:0]   adj;

    assign inv_a = 8'd255 - i_alpha;
    // sum tops out at 255*255, so the product terms never carry out
    assign sum   = PW'(i_bg) * PW'(inv_a) + PW'(i_ovl) * PW'(i_alpha);
    // exact divide by 255 for sums up to 255*255
    assign adj   = sum + PW'(1) + (sum >> CH_W);
    assign o_res = i_en ? adj[PW-1:CH_W] : i_bg;

endmodule
